// ----- sv/enet_penalty_weight_update_assert.svh -----
// assertion macros for the penalty weight update block
`ifndef ENET_PENALTY_WEIGHT_UPDATE_ASSERT_SVH
`define ENET_PENALTY_WEIGHT_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define EPWU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define EPWU_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");
`else
`define EPWU_ASSERT(lbl, clk, rst, prop)
`define EPWU_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- sv/epwu_pkg.sv -----
// shared types and constants for the penalty weight update block
package epwu_pkg;
   localparam int COEF_W = 32;
   localparam int FRAC_W = 16;
   localparam int W_W    = 32;
   localparam int RSS_W  = 48;
   localparam int ABS_W  = 48;
   localparam int SQ_W   = 64;
   localparam int DVD_W  = 80;
   localparam int DIV_W  = 64;
   localparam int CNT_W  = 7;
   localparam int ACC_W  = 88;

   localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd80;
   localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;
   localparam logic [DIV_W-1:0] SQRT_ONE   = 64'h4000_0000_0000_0000;

   typedef enum logic {
      OP_DIV,
      OP_SQRT
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

   typedef enum logic [1:0] {
      REG_L1_WEIGHT       = 2'd0,
      REG_L2_WEIGHT       = 2'd1,
      REG_SAMPLE_COUNT    = 2'd2,
      REG_COVARIATE_COUNT = 2'd3
   } csr_index_type;
endpackage

// ----- sv/epwu_mult.sv -----
// shared registered 32x32 unsigned multiplier
module epwu_mult (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);
   import epwu_pkg::*;

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;
endmodule

// ----- sv/epwu_iter.sv -----
// shared iterative unit: restoring division and bitwise square root, one bit per cycle
module epwu_iter (
   input  logic                          clock,
   input  logic                          reset,
   input  epwu_pkg::iter_cmd_type        cmd,
   input  logic [epwu_pkg::DVD_W-1:0]    dividend,
   input  logic [epwu_pkg::DIV_W-1:0]    divisor,
   output epwu_pkg::iter_stat_type       stat,
   output logic [epwu_pkg::DVD_W-1:0]    quotient,
   output logic [epwu_pkg::W_W-1:0]      root
);
   import epwu_pkg::*;

   iter_op_type      op_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [DVD_W-1:0] work_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dsr_ff;

   logic [DIV_W:0]   div_t;
   logic [DIV_W:0]   div_diff;
   logic             div_ge;
   logic [DIV_W-1:0] sq_sum;
   logic             sq_ge;
   logic [DVD_W-1:0] work_in;
   logic [DIV_W-1:0] rem_in;
   logic [DIV_W-1:0] dsr_in;

   always_comb begin
      div_t    = {rem_ff, work_ff[DVD_W-1]};
      div_diff = div_t - {1'b0, dsr_ff};
      div_ge   = div_t >= {1'b0, dsr_ff};
      sq_sum   = rem_ff + dsr_ff;
      sq_ge    = work_ff[DIV_W-1:0] >= sq_sum;
      unique case (op_ff)
         OP_DIV: begin
            work_in = {work_ff[DVD_W-2:0], div_ge};
            rem_in  = div_ge ? div_diff[DIV_W-1:0] : div_t[DIV_W-1:0];
            dsr_in  = dsr_ff;
         end
         OP_SQRT: begin
            work_in = {work_ff[DVD_W-1:DIV_W],
                       sq_ge ? (work_ff[DIV_W-1:0] - sq_sum) : work_ff[DIV_W-1:0]};
            rem_in  = sq_ge ? ((rem_ff >> 1) + dsr_ff) : (rem_ff >> 1);
            dsr_in  = dsr_ff >> 2;
         end
         default: begin
            work_in = work_ff;
            rem_in  = rem_ff;
            dsr_in  = dsr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_W'(1));
         if (cmd.start) begin
            op_ff  <= cmd.op;
            rem_ff <= '0;
            if (cmd.op == OP_SQRT) begin
               cnt_ff  <= SQRT_STEPS;
               work_ff <= {{(DVD_W-DIV_W){1'b0}}, dividend[DIV_W-1:0]};
               dsr_ff  <= SQRT_ONE;
            end else begin
               cnt_ff  <= DIV_STEPS;
               work_ff <= dividend;
               dsr_ff  <= divisor;
            end
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - CNT_W'(1);
            work_ff <= work_in;
            rem_ff  <= rem_in;
            dsr_ff  <= dsr_in;
         end
      end
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = work_ff;
   assign root      = rem_ff[W_W-1:0];
endmodule

// ----- sv/enet_penalty_weight_update.sv -----
// elastic-net penalty weight and noise variance update, top level
// Usage: one coefficient transaction enters on the req_ channel (valid/ready) and
// gives exactly one result transaction on the rsp_ channel. Each result carries
// the weight sqrt(|b|/(l1+l2|b|)) in Q16.16; a transaction marked last also
// carries the noise variance over the whole vector and clears the running sums.
// Each coefficient runs an 80-step division and a 32-step root on the shared
// iterative unit; the root is skipped on a quotient overflow and both on a zero
// denominator. A last coefficient adds a variance division unless its numerator saturates.
// Throughput: one coefficient at a time; req_ready is high only while idle.
// The result sits in an output register, so a stalled receiver does not block
// the next computation until that one also finishes.
// Reset: synchronous, clears the sums and loads l1=1.0, l2=0, n=1, p=1.
// Registers are written over the csr_ port at byte addresses 0, 4, 8, 12; the user must
// write them only while no transaction is in flight, and the block does not enforce this.
`include "enet_penalty_weight_update_assert.svh"
module enet_penalty_weight_update (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [epwu_pkg::COEF_W-1:0] req_coef_value,
   input  logic [epwu_pkg::RSS_W-1:0]   req_residual_norm,
   input  logic                         req_last_coef,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [epwu_pkg::W_W-1:0]     rsp_root_weight,
   output logic [epwu_pkg::RSS_W-1:0]   rsp_noise_variance,
   output logic                         rsp_variance_valid,
   output logic                         rsp_zero_denominator,
   output logic                         rsp_last_out,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import epwu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MD, S_MSQ, S_ACC, S_DW, S_SQ, S_POST,
      S_ML0, S_ML1, S_ML2, S_NUM, S_DV, S_FIN
   } state_type;

   state_type         state_ff;
   logic [31:0]       l1_ff;
   logic [31:0]       l2_ff;
   logic [15:0]       n_ff;
   logic [12:0]       p_ff;
   logic [ABS_W-1:0]  abs_sum_ff;
   logic [SQ_W-1:0]   sq_sum_ff;
   logic [COEF_W-1:0] mag_ff;
   logic              last_ff;
   logic [RSS_W-1:0]  rss_ff;
   logic [DIV_W-1:0]  den_ff;
   logic              zden_ff;
   logic [W_W-1:0]    weight_ff;
   logic [RSS_W-1:0]  var_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic              rsp_valid_ff;
   logic [W_W-1:0]    out_weight_ff;
   logic [RSS_W-1:0]  out_var_ff;
   logic              out_zden_ff;
   logic              out_last_ff;

   logic [COEF_W-1:0] mag_in;
   logic [31:0]       mul_a;
   logic [31:0]       mul_b;
   logic [63:0]       prod;
   iter_cmd_type      iter_cmd;
   iter_stat_type     iter_stat;
   logic [DVD_W-1:0]  iter_dvd;
   logic [DIV_W-1:0]  iter_dsr;
   logic [DVD_W-1:0]  quot;
   logic [W_W-1:0]    root;
   logic [DIV_W:0]    den_sum;
   logic [ABS_W:0]    abs_add;
   logic [SQ_W:0]     sq_add;
   logic [SQ_W:0]     num1;
   logic [SQ_W:0]     num2;
   logic              num_sat;
   logic [16:0]       m_sum;
   logic [16:0]       m_div;
   logic              csr_wr;
   logic              out_load;

   assign mag_in = req_coef_value[COEF_W-1] ? (~req_coef_value + COEF_W'(1))
                                             : req_coef_value;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign out_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      den_sum = {1'b0, 16'b0, l1_ff, 16'b0} + {1'b0, prod};
      abs_add = {1'b0, abs_sum_ff} + {17'b0, mag_ff};
      sq_add  = {1'b0, sq_sum_ff} + {1'b0, prod};
      num1    = {1'b0, rss_ff, 16'b0} + {1'b0, acc_ff[SQ_W-1:0]};
      num2    = {1'b0, num1[SQ_W-1:0]} + {1'b0, sq_sum_ff};
      num_sat = (acc_ff[ACC_W-1:SQ_W] != '0) | num1[SQ_W] | num2[SQ_W];
      m_sum   = {1'b0, n_ff} + {4'b0, p_ff};
      m_div   = (m_sum < 17'd2) ? 17'd1 : (m_sum - 17'd1);
   end

   always_comb begin
      unique case (state_ff)
         S_MD: begin
            mul_a = l2_ff;
            mul_b = mag_ff;
         end
         S_MSQ: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         S_ML0: begin
            mul_a = l1_ff;
            mul_b = {8'b0, abs_sum_ff[23:0]};
         end
         S_ML1: begin
            mul_a = l1_ff;
            mul_b = {8'b0, abs_sum_ff[47:24]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      iter_cmd.start = 1'b0;
      iter_cmd.op    = OP_DIV;
      iter_dvd       = {mag_ff, 48'b0};
      iter_dsr       = den_ff;
      unique case (state_ff)
         S_ACC: begin
            iter_cmd.start = !zden_ff;
         end
         S_DW: begin
            iter_cmd.start = iter_stat.done && (quot[DVD_W-1:DIV_W] == '0);
            iter_cmd.op    = OP_SQRT;
            iter_dvd       = {16'b0, quot[DIV_W-1:0]};
         end
         S_NUM: begin
            iter_cmd.start = !num_sat;
            iter_dvd       = {16'b0, num2[SQ_W-1:0]};
            iter_dsr       = {47'b0, m_div};
         end
         default: begin
            iter_cmd.start = 1'b0;
         end
      endcase
   end

   epwu_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   epwu_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (iter_cmd),
      .dividend (iter_dvd),
      .divisor  (iter_dsr),
      .stat     (iter_stat),
      .quotient (quot),
      .root     (root)
   );

   always_comb begin
      unique case (csr_index_type'(csr_paddr[3:2]))
         REG_L1_WEIGHT:       csr_prdata = l1_ff;
         REG_L2_WEIGHT:       csr_prdata = l2_ff;
         REG_SAMPLE_COUNT:    csr_prdata = {16'b0, n_ff};
         REG_COVARIATE_COUNT: csr_prdata = {19'b0, p_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         l1_ff        <= 32'd65536;
         l2_ff        <= '0;
         n_ff         <= 16'd1;
         p_ff         <= 13'd1;
         abs_sum_ff   <= '0;
         sq_sum_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index_type'(csr_paddr[3:2]))
               REG_L1_WEIGHT:       l1_ff <= csr_pwdata;
               REG_L2_WEIGHT:       l2_ff <= csr_pwdata;
               REG_SAMPLE_COUNT:    n_ff  <= csr_pwdata[15:0];
               REG_COVARIATE_COUNT: p_ff  <= csr_pwdata[12:0];
               default:             l1_ff <= l1_ff;
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mag_ff   <= mag_in;
                  last_ff  <= req_last_coef;
                  rss_ff   <= req_residual_norm;
                  var_ff   <= '0;
                  state_ff <= S_MD;
               end
            end
            S_MD: state_ff <= S_MSQ;
            S_MSQ: begin
               den_ff   <= den_sum[DIV_W] ? '1 : den_sum[DIV_W-1:0];
               zden_ff  <= (den_sum == '0);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               abs_sum_ff <= abs_add[ABS_W] ? '1 : abs_add[ABS_W-1:0];
               sq_sum_ff  <= sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
               if (zden_ff) begin
                  weight_ff <= '0;
                  state_ff  <= S_POST;
               end else begin
                  state_ff  <= S_DW;
               end
            end
            S_DW: begin
               if (iter_stat.done) begin
                  if (quot[DVD_W-1:DIV_W] != '0) begin
                     weight_ff <= '1;
                     state_ff  <= S_POST;
                  end else begin
                     state_ff  <= S_SQ;
                  end
               end
            end
            S_SQ: begin
               if (iter_stat.done) begin
                  weight_ff <= root;
                  state_ff  <= S_POST;
               end
            end
            S_POST: state_ff <= last_ff ? S_ML0 : S_FIN;
            S_ML0: state_ff <= S_ML1;
            S_ML1: begin
               acc_ff   <= {24'b0, prod};
               state_ff <= S_ML2;
            end
            S_ML2: begin
               acc_ff   <= acc_ff + {prod, 24'b0};
               state_ff <= S_NUM;
            end
            S_NUM: begin
               abs_sum_ff <= '0;
               sq_sum_ff  <= '0;
               if (num_sat) begin
                  var_ff   <= '1;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_DV;
               end
            end
            S_DV: begin
               if (iter_stat.done) begin
                  var_ff   <= quot[SQ_W-1:FRAC_W];
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_load) begin
                  out_weight_ff <= weight_ff;
                  out_var_ff    <= var_ff;
                  out_zden_ff   <= zden_ff;
                  out_last_ff   <= last_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_root_weight      = out_weight_ff;
   assign rsp_noise_variance   = out_var_ff;
   assign rsp_variance_valid   = out_last_ff;
   assign rsp_zero_denominator = out_zden_ff;
   assign rsp_last_out         = out_last_ff;

   `EPWU_NEVER(a_start_busy, clock, reset, iter_cmd.start && iter_stat.busy)
   `EPWU_NEVER(a_div_zero_den, clock, reset, (state_ff == S_DW) && zden_ff)
   `EPWU_ASSERT(a_sums_cleared, clock, reset,
      (state_ff == S_NUM) |=> (abs_sum_ff == '0) && (sq_sum_ff == '0))
   `EPWU_ASSERT(a_zden_weight, clock, reset,
      (rsp_valid && rsp_zero_denominator) |-> (rsp_root_weight == '0))
   `EPWU_ASSERT(a_var_only_last, clock, reset,
      (rsp_valid && !rsp_variance_valid) |-> (rsp_noise_variance == '0))
endmodule

// ----- tb/sv/epwu_checker.sv -----
// checker for the penalty weight update block: tracks registers, predicts and compares results
module epwu_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [epwu_pkg::COEF_W-1:0] req_coef_value,
   input  logic [epwu_pkg::RSS_W-1:0]        req_residual_norm,
   input  logic                              req_last_coef,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [epwu_pkg::W_W-1:0]          rsp_root_weight,
   input  logic [epwu_pkg::RSS_W-1:0]        rsp_noise_variance,
   input  logic                              rsp_variance_valid,
   input  logic                              rsp_zero_denominator,
   input  logic                              rsp_last_out,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [3:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending
);
   import epwu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [W_W-1:0]   weight;
      logic [RSS_W-1:0] variance;
      logic             var_valid;
      logic             zden;
      logic             last;
   } weight_result_type;

   localparam logic [63:0] SUM64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [47:0] SUM48_MAX = 48'hFFFF_FFFF_FFFF;

   weight_result_type expected_q[$];
   logic [31:0] l1_w, l2_w;
   logic [15:0] n_samples;
   logic [12:0] n_covariates;
   logic [47:0] mag_total;
   logic [63:0] sq_total;

   assign pending = expected_q.size();

   function automatic logic [31:0] int_sqrt(logic [63:0] x);
      logic [31:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = {32'd0, root | (32'd1 << i)};
         if (trial * trial <= x) root = trial[31:0];
      end
      return root;
   endfunction

   function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b, ref logic sat);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) begin
         sat = 1'b1;
         return SUM64_MAX;
      end
      return s[63:0];
   endfunction

   task automatic predict_coef(logic signed [COEF_W-1:0] coef, logic [RSS_W-1:0] rss,
                               logic last);
      weight_result_type r;
      logic [31:0]  mag;
      logic [64:0]  den;
      logic [127:0] quo;
      logic [127:0] prod;
      logic [63:0]  num, div_by;
      logic [48:0]  abs_next;
      logic         sat, dummy;
      mag = coef[31] ? (~coef + 32'd1) : coef;
      den = ({33'd0, l1_w} << 16) + {33'd0, l2_w} * {33'd0, mag};
      r.zden = 1'b0;
      r.weight = '0;
      if (den == 0) r.zden = 1'b1;
      else begin
         quo = ({96'd0, mag} << 48) / {63'd0, den};
         if (quo[127:64] != 0) r.weight = '1;
         else r.weight = int_sqrt(quo[63:0]);
      end
      abs_next = {1'b0, mag_total} + {17'd0, mag};
      mag_total = abs_next[48] ? SUM48_MAX : abs_next[47:0];
      dummy = 1'b0;
      sq_total = add_sat64(sq_total, {32'd0, mag} * {32'd0, mag}, dummy);
      r.variance = '0;
      r.var_valid = last;
      r.last = last;
      if (last) begin
         sat = 1'b0;
         num = {rss, 16'd0};
         prod = {96'd0, l1_w} * {80'd0, mag_total};
         if (prod[127:64] != 0) begin
            sat = 1'b1;
            prod = {64'd0, SUM64_MAX};
         end
         num = add_sat64(num, prod[63:0], sat);
         num = add_sat64(num, sq_total, sat);
         div_by = {48'd0, n_samples} + {51'd0, n_covariates};
         div_by = (div_by < 2) ? 64'd1 : div_by - 64'd1;
         if (sat) r.variance = SUM48_MAX;
         else begin
            num = (num / div_by) >> 16;
            r.variance = (num[63:48] != 0) ? SUM48_MAX : num[47:0];
         end
         mag_total = '0;
         sq_total = '0;
      end
      expected_q.push_back(r);
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      weight_result_type w;
      if (reset) begin
         l1_w <= 32'd65536;
         l2_w <= '0;
         n_samples <= 16'd1;
         n_covariates <= 13'd1;
         mag_total = '0;
         sq_total = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               REG_L1_WEIGHT:       l1_w <= csr_pwdata;
               REG_L2_WEIGHT:       l2_w <= csr_pwdata;
               REG_SAMPLE_COUNT:    n_samples <= csr_pwdata[15:0];
               REG_COVARIATE_COUNT: n_covariates <= csr_pwdata[12:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_coef(req_coef_value, req_residual_norm, req_last_coef);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("unexpected result transaction at %0t", $realtime);
               fail_count++;
            end else begin
               w = expected_q.pop_front();
               if (rsp_root_weight !== w.weight) report("root_weight", rsp_root_weight, w.weight);
               if (rsp_noise_variance !== w.variance)
                  report("noise_variance", rsp_noise_variance, w.variance);
               if (rsp_variance_valid !== w.var_valid)
                  report("variance_valid", rsp_variance_valid, w.var_valid);
               if (rsp_zero_denominator !== w.zden)
                  report("zero_denominator", rsp_zero_denominator, w.zden);
               if (rsp_last_out !== w.last) report("last_out", rsp_last_out, w.last);
            end
         end
      end
   end
endmodule

// ----- tb/sv/tb.sv -----
// testbench top: clock, reset, stimulus, register phases and verdict
module tb;
   import epwu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COEF_W-1:0] req_coef_value = '0;
   logic [RSS_W-1:0] req_residual_norm = '0;
   logic req_last_coef = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [W_W-1:0] rsp_root_weight;
   logic [RSS_W-1:0] rsp_noise_variance;
   logic rsp_variance_valid, rsp_zero_denominator, rsp_last_out;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending;
   int idle_cycles = 0;
   bit no_stall = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   enet_penalty_weight_update DUT (.*);

   epwu_checker u_checker (.*);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!no_stall && $urandom_range(0, 5) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_penalty(logic [31:0] l1, logic [31:0] l2, logic [15:0] n,
                              logic [12:0] p);
      csr_write(REG_L1_WEIGHT, l1);
      csr_write(REG_L2_WEIGHT, l2);
      csr_write(REG_SAMPLE_COUNT, {16'd0, n});
      csr_write(REG_COVARIATE_COUNT, {19'd0, p});
   endtask

   task automatic drain;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_coef(logic signed [31:0] coef, logic [47:0] rss, logic last,
                            bit gaps);
      int gap;
      gap = 0;
      if (gaps) gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if (!req_valid) begin
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coef_value <= coef;
      req_residual_norm <= rss;
      req_last_coef <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   function automatic logic signed [31:0] rand_coef();
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 255);
         2: v = $urandom >> $urandom_range(0, 31);
         3: v = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: v = $urandom >> $urandom_range(8, 20);
      endcase
      if ($urandom_range(0, 1) != 0) v = -v;
      return v;
   endfunction

   function automatic logic [47:0] rand_rss();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0] >> $urandom_range(0, 47);
   endfunction

   task automatic finish_line;
      req_valid <= 1'b0;
      drain();
   endtask

   initial begin
      logic [31:0] l1, l2;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings
      send_coef(32'sd0, 48'd0, 1'b0, 1'b0);
      send_coef(32'sh7FFF_FFFF, 48'd0, 1'b0, 1'b0);
      send_coef(32'sh8000_0000, 48'd0, 1'b0, 1'b0);
      send_coef(-32'sd1, 48'd0, 1'b0, 1'b0);
      send_coef(32'sd1, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      send_coef(32'sh0001_0000, 48'd0, 1'b1, 1'b0);
      finish_line();

      // zero denominator, then saturating penalties
      set_penalty(32'd0, 32'd0, 16'd1, 13'd1);
      send_coef(32'sd0, 48'd5, 1'b0, 1'b0);
      send_coef(32'sh1234_5678, 48'd5, 1'b0, 1'b0);
      send_coef(32'sh8000_0000, 48'h0000_FFFF_FFFF, 1'b1, 1'b0);
      finish_line();
      set_penalty(32'd0, 32'hFFFF_FFFF, 16'd65535, 13'd4096);
      send_coef(32'sd0, 48'd0, 1'b0, 1'b0);
      send_coef(32'sd1, 48'd0, 1'b0, 1'b0);
      send_coef(32'sh8000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      finish_line();
      set_penalty(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 13'd4096);
      send_coef(32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
      send_coef(32'sh8000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      send_coef(32'sd1, 48'd1, 1'b1, 1'b0);
      finish_line();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin l1 = $urandom >> $urandom_range(8, 24); l2 = $urandom >> 20; end
            1: begin l1 = $urandom; l2 = $urandom; end
            2: begin l1 = 32'd0; l2 = $urandom_range(0, 3); end
            default: begin l1 = 32'h0001_0000; l2 = $urandom >> $urandom_range(0, 31); end
         endcase
         set_penalty(l1, l2, $urandom_range(1, 65535), $urandom_range(1, 4096));
         no_stall = (phase == 3);
         for (int k = 0; k < 100; k++)
            send_coef(rand_coef(), rand_rss(), $urandom_range(0, 7) == 0, phase != 5);
         finish_line();
      end

      if (fail_count == 0 && pending == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ----- enet_penalty_weight_update.f -----
+incdir+sv
sv/epwu_pkg.sv
sv/epwu_mult.sv
sv/epwu_iter.sv
sv/enet_penalty_weight_update.sv
tb/sv/epwu_checker.sv
tb/sv/tb.sv
